[hw/rtl/adc_channel_moving_average_top_defines.svh]
// ----------------------------------------------------------------------------
// adc_channel_moving_average_top_defines
// Assertion macros of the moving-average RTL.
// ----------------------------------------------------------------------------
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef ADC_CHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH
`define ADC_CHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define AMA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("moving average: same-cycle check failed");
// Next-cycle implication.
`define AMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("moving average: next-cycle check failed");
`else
`define AMA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define AMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/adc_ma_pkg.sv]
// ----------------------------------------------------------------------------
// adc_ma_pkg
// Shared types and constants of the ADC channel moving-average filter.
// ----------------------------------------------------------------------------
package adc_ma_pkg;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SIZE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELECT_UNIT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELECT_CHANNEL = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNIT0_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNIT1_COUNT    = 3'd4;

   // Record tag widths
   localparam int UNIT_BITS    = 1;
   localparam int CHANNEL_BITS = 3;
   localparam int COUNT_BITS   = 4;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] WINDOW_SIZE_RST    = 9'd16;
   localparam logic [UNIT_BITS-1:0]     SELECT_UNIT_RST    = 1'b0;
   localparam logic [CHANNEL_BITS-1:0]  SELECT_CHANNEL_RST = 3'd0;
   localparam logic [COUNT_BITS-1:0]    UNIT0_COUNT_RST    = 4'd5;
   localparam logic [COUNT_BITS-1:0]    UNIT1_COUNT_RST    = 4'd1;

   // Commands from the top level to the window store
   typedef struct packed {
      logic clear;   // empty the window, sum and position
      logic fetch;   // read the entry at the write position
      logic commit;  // write the new sample and update the sum
   } win_ctrl_type;

   // Divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[hw/rtl/adc_ma_window.sv]
// ----------------------------------------------------------------------------
// adc_ma_window
// Circular sample store with running sum and write position. One synchronous
// memory, read in the cycle before the read-modify-write commit.
// ----------------------------------------------------------------------------
module adc_ma_window
   import adc_ma_pkg::*;
#(
   parameter int WINDOW_MAX  = 256,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  win_ctrl_type                              ctrl,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]           win,
   input  logic [SAMPLE_BITS-1:0]                    sample,
   output logic [SAMPLE_BITS+$clog2(WINDOW_MAX)-1:0] sum
);

   localparam int IDX_BITS = $clog2(WINDOW_MAX);
   localparam int WIN_BITS = $clog2(WINDOW_MAX+1);
   localparam int SUM_BITS = SAMPLE_BITS + IDX_BITS;

   logic [SAMPLE_BITS-1:0] window_mem_ff [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [IDX_BITS-1:0]    pos_ff, pos_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic [WIN_BITS-1:0]    pos_next;
   logic                   pos_wrap;

   // Memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         window_mem_ff[pos_ff] <= sample;
      end
      if (ctrl.fetch) begin
         rd_data_ff <= window_mem_ff[pos_ff];
      end
   end

   // Entries are filled in order from zero, so until the first wrap the
   // entry at the write position was never written and counts as zero
   assign old_sample = wrapped_ff ? rd_data_ff : '0;

   assign sum_in   = sum_ff + SUM_BITS'(sample) - SUM_BITS'(old_sample);
   assign pos_next = WIN_BITS'(pos_ff) + WIN_BITS'(1);
   assign pos_wrap = (pos_next >= win);
   assign pos_in   = pos_wrap ? '0 : IDX_BITS'(pos_next);
   assign wrapped_in = wrapped_ff | pos_wrap;

   // Advance sum and position on commit, drop everything on clear
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else if (ctrl.commit) begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign sum = sum_ff;

endmodule

[hw/rtl/adc_ma_div.sv]
// ----------------------------------------------------------------------------
// adc_ma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adc_ma_div
   import adc_ma_pkg::*;
#(
   parameter int DIVIDEND_BITS = 20,
   parameter int DIVISOR_BITS  = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output div_stat_type             status
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS+1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  div_ff;
   logic [CNT_BITS-1:0]      count_ff;
   logic                     done_ff;
   logic [DIVISOR_BITS:0]    rem_shift;
   logic [DIVISOR_BITS:0]    rem_diff;
   logic                     fits;

   // One restoring step: bring down the next dividend bit, try a subtract
   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign fits      = (rem_shift >= {1'b0, div_ff});
   assign rem_in    = fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
   assign quo_in    = {quo_ff[DIVIDEND_BITS-2:0], fits};

   // Datapath: load on start, iterate while the count runs
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (count_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else if (start) begin
         count_ff <= CNT_BITS'(DIVIDEND_BITS);
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (count_ff == CNT_BITS'(1));
         if (count_ff != '0) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;

endmodule

[hw/rtl/adc_channel_moving_average_top.sv]
// ----------------------------------------------------------------------------
// adc_channel_moving_average_top
// Sliding-window moving average over one selected ADC unit and channel.
// ----------------------------------------------------------------------------
// Each record on the req_ stream is checked against the channel count of its
// unit and against the selected unit and channel; a record that fails either
// check is consumed on transfer and gives no result. A matching record
// replaces the oldest sample of a circular window held in a single-port
// synchronous RAM (read, then written back in the next cycle), updates the
// running sum, and yields sum / window on the rsp_ stream. A matching record
// passes through the commit, the divider start, the bit-serial division (one
// quotient bit per cycle) and the output step, which waits until the output
// register is free; the next record is taken once the result sits in the
// output register. Writing window_size, even with its current value, empties
// the window; this takes effect at once and needs no clearing pass, since
// unwritten entries read as zero until the write position first wraps.
// ----------------------------------------------------------------------------
`include "adc_channel_moving_average_top_defines.svh"

module adc_channel_moving_average_top
   import adc_ma_pkg::*;
#(
   parameter int WINDOW_MAX  = 256,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Record stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: unit [0], channel [3:1], sample [3+SAMPLE_BITS:4], zero fill
   input  logic [((SAMPLE_BITS+4+7)/8)*8-1:0]     req_tdata,
   // Result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: average [SAMPLE_BITS-1:0], zero fill
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,
   // Configuration write port
   input  logic                                   csr_we,
   input  logic [CSR_INDEX_BITS-1:0]              csr_index,
   input  logic [CSR_DATA_BITS-1:0]               csr_wdata
);

   localparam int IDX_BITS = $clog2(WINDOW_MAX);
   localparam int WIN_BITS = $clog2(WINDOW_MAX+1);
   localparam int SUM_BITS = SAMPLE_BITS + IDX_BITS;
   localparam int RSP_BITS = ((SAMPLE_BITS+7)/8)*8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                state_ff;
   logic [CSR_DATA_BITS-1:0] window_size_ff;
   logic [UNIT_BITS-1:0]     select_unit_ff;
   logic [CHANNEL_BITS-1:0]  select_channel_ff;
   logic [COUNT_BITS-1:0]    unit0_count_ff;
   logic [COUNT_BITS-1:0]    unit1_count_ff;
   logic [SAMPLE_BITS-1:0]   sample_ff;
   logic                     rsp_tvalid_ff;
   logic [SAMPLE_BITS-1:0]   average_ff, average_in;

   logic [UNIT_BITS-1:0]     req_unit;
   logic [CHANNEL_BITS-1:0]  req_channel;
   logic [SAMPLE_BITS-1:0]   req_sample;
   logic [COUNT_BITS-1:0]    unit_count;
   logic                     req_xfer;
   logic                     req_match;
   logic                     out_free;
   logic [WIN_BITS-1:0]      win;
   logic [SUM_BITS-1:0]      sum;
   logic [SUM_BITS-1:0]      quotient;
   win_ctrl_type             win_ctrl;
   div_stat_type             div_stat;

   // Unpack the record
   assign req_unit    = req_tdata[0];
   assign req_channel = req_tdata[3:1];
   assign req_sample  = req_tdata[4 +: SAMPLE_BITS];

   // Keep channels below the unit's count and only the selected pair
   assign unit_count = (req_unit != '0) ? unit1_count_ff : unit0_count_ff;
   assign req_match  = (COUNT_BITS'(req_channel) < unit_count)
                     && (req_unit == select_unit_ff)
                     && (req_channel == select_channel_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Effective window: zero acts as one, large values saturate
   always_comb begin
      if (window_size_ff == '0) begin
         win = WIN_BITS'(1);
      end else if (32'(window_size_ff) > 32'(WINDOW_MAX)) begin
         win = WIN_BITS'(WINDOW_MAX);
      end else begin
         win = WIN_BITS'(window_size_ff);
      end
   end

   // Saturate the quotient to the sample range
   assign average_in = (quotient[SUM_BITS-1:SAMPLE_BITS] != '0) ? '1
                     : quotient[SAMPLE_BITS-1:0];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff    <= WINDOW_SIZE_RST;
         select_unit_ff    <= SELECT_UNIT_RST;
         select_channel_ff <= SELECT_CHANNEL_RST;
         unit0_count_ff    <= UNIT0_COUNT_RST;
         unit1_count_ff    <= UNIT1_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SIZE:    window_size_ff    <= csr_wdata;
            CSR_SELECT_UNIT:    select_unit_ff    <= csr_wdata[UNIT_BITS-1:0];
            CSR_SELECT_CHANNEL: select_channel_ff <= csr_wdata[CHANNEL_BITS-1:0];
            CSR_UNIT0_COUNT:    unit0_count_ff    <= csr_wdata[COUNT_BITS-1:0];
            CSR_UNIT1_COUNT:    unit1_count_ff    <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Store commands
   assign win_ctrl.clear  = csr_we && (csr_index == CSR_WINDOW_SIZE);
   assign win_ctrl.fetch  = req_xfer && req_match;
   assign win_ctrl.commit = (state_ff == ST_UPDATE);

   // Sequencer with result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // drop a taken result unless the output step reloads it
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer && req_match) begin
                  sample_ff <= req_sample;
                  state_ff  <= ST_UPDATE;
               end
            end
            ST_UPDATE: state_ff <= ST_START;
            ST_START:  state_ff <= ST_DIV;
            ST_DIV: begin
               if (div_stat.done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  average_ff    <= average_in;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   adc_ma_window #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (win_ctrl),
      .win    (win),
      .sample (sample_ff),
      .sum    (sum)
   );

   adc_ma_div #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (WIN_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_START),
      .dividend (sum),
      .divisor  (win),
      .quotient (quotient),
      .status   (div_stat)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_BITS'(average_ff);

   // A finished division is only seen while the sequencer waits for it
   `AMA_ASSERT_IMPLIES(a_done_in_div, clock, reset, div_stat.done, state_ff == ST_DIV)
   // No new record is taken while the divider still runs
   `AMA_ASSERT_IMPLIES(a_idle_div_quiet, clock, reset, req_tready, !div_stat.busy)
   // A result appears only after the sequencer passed through the output step
   `AMA_ASSERT_IMPLIES(a_rsp_from_out, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_OUT)
   // A commit is followed by the divider start
   `AMA_ASSERT_NEXT(a_commit_then_start, clock, reset, win_ctrl.commit, state_ff == ST_START)

endmodule
